// ===== sv/rbsi_pkg.sv =====
// ----------------------------------------------------------------------------
// rbsi_pkg
// Shared widths, defaults and types for the ray/box slab intersect block.
// ----------------------------------------------------------------------------
package rbsi_pkg;

    // fixed field widths
    localparam int COORD_W = 32;
    localparam int SIZE_W  = 31;
    localparam int NORM_W  = 2;

    // default fraction bits of the fixed point format
    localparam int FRAC_BITS_DEF = 16;

    // normal codes
    localparam logic signed [NORM_W-1:0] NORM_NEG  = -2'sd1;
    localparam logic signed [NORM_W-1:0] NORM_ZERO = 2'sd0;
    localparam logic signed [NORM_W-1:0] NORM_POS  = 2'sd1;

    // per-item data that rides beside the dividers
    typedef struct packed {
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_y;
        logic signed [COORD_W-1:0] dir_x;
        logic signed [COORD_W-1:0] dir_y;
        logic                      neg_xa;
        logic                      neg_xb;
        logic                      neg_ya;
        logic                      neg_yb;
        logic                      zero_x;
        logic                      zero_y;
        logic                      slab_x;
        logic                      slab_y;
    } side_t;

endpackage

// ===== sv/rbsi_in_if.sv =====
// ----------------------------------------------------------------------------
// rbsi_in_if
// Query channel: one ray and one rectangle per item.
// ----------------------------------------------------------------------------
interface rbsi_in_if;
    import rbsi_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [COORD_W-1:0] dir_x;
    logic signed [COORD_W-1:0] dir_y;
    logic signed [COORD_W-1:0] box_x;
    logic signed [COORD_W-1:0] box_y;
    logic        [SIZE_W-1:0]  box_w;
    logic        [SIZE_W-1:0]  box_h;

    modport source (
        output valid, origin_x, origin_y, dir_x, dir_y, box_x, box_y, box_w, box_h,
        input  ready
    );

    modport sink (
        input  valid, origin_x, origin_y, dir_x, dir_y, box_x, box_y, box_w, box_h,
        output ready
    );

endinterface

// ===== sv/rbsi_out_if.sv =====
// ----------------------------------------------------------------------------
// rbsi_out_if
// Result channel: hit flag, entry time, contact point and face normal.
// ----------------------------------------------------------------------------
interface rbsi_out_if;
    import rbsi_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      hit;
    logic signed [COORD_W-1:0] near_time;
    logic signed [COORD_W-1:0] contact_x;
    logic signed [COORD_W-1:0] contact_y;
    logic signed [NORM_W-1:0]  normal_x;
    logic signed [NORM_W-1:0]  normal_y;

    modport source (
        output valid, hit, near_time, contact_x, contact_y, normal_x, normal_y,
        input  ready
    );

    modport sink (
        input  valid, hit, near_time, contact_x, contact_y, normal_x, normal_y,
        output ready
    );

endinterface

// ===== sv/ray_box_slab_intersect.sv =====
// ----------------------------------------------------------------------------
// ray_box_slab_intersect
// 2D ray versus axis-aligned rectangle by the slab method, fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one query per item: ray origin and direction, rectangle
//   left/top edge, width and height, all Q(31-FRAC_BITS).FRAC_BITS.
//   rsp carries one result per query, in order: hit, near_time, contact
//   point and face normal. A miss returns hit = 0 and all other fields 0.
// Throughput: one item per cycle, sustained while the output is not stalled.
// Pipeline: input register, slab stage, then the four entry/exit time
//   dividers, which retire one quotient bit per stage over 33 + FRAC_BITS
//   stages, then p1 to p4 and the output register that drives rsp.
// Reset: rst_n clears all valid bits; the pipeline comes up empty and
//   req.ready is high.
// Stall: the whole pipeline holds while rsp.valid is high and rsp.ready
//   is low; req.ready then drops. Nothing is lost or repeated.
// ----------------------------------------------------------------------------
module ray_box_slab_intersect
    import rbsi_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic  clk,
    input  logic  rst_n,
    rbsi_in_if.sink    req,
    rbsi_out_if.source rsp
);

    localparam int NUM_W = 33 + FRAC_BITS;
    localparam int DEN_W = COORD_W;
    localparam int TW    = NUM_W + 2;
    localparam int PW    = 2 * COORD_W;

    localparam logic signed [TW-1:0] T_NEG_INF = {1'b1, {(TW-1){1'b0}}};
    localparam logic signed [TW-1:0] T_POS_INF = {1'b0, {(TW-1){1'b1}}};

    // saturate a time to 32 bits
    function automatic logic signed [COORD_W-1:0] sat_time(input logic signed [TW-1:0] v);
        logic [TW-COORD_W:0] top;
        top = v[TW-1:COORD_W-1];
        if ((top == '0) || (top == '1))
            return v[COORD_W-1:0];
        return v[TW-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    endfunction

    // saturate a contact coordinate to 32 bits
    function automatic logic signed [COORD_W-1:0] sat_pos(input logic signed [PW:0] v);
        logic [PW-COORD_W+1:0] top;
        top = v[PW:COORD_W-1];
        if ((top == '0) || (top == '1))
            return v[COORD_W-1:0];
        return v[PW] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    endfunction

    // signed time from quotient magnitude
    function automatic logic signed [TW-1:0] to_time(input logic [NUM_W-1:0] mag,
                                                     input logic neg);
        logic signed [TW-1:0] t;
        t = $signed({2'b00, mag});
        return neg ? -t : t;
    endfunction

    // global advance: the pipeline moves unless the output is full and stalled
    logic en;
    assign en        = !rsp.valid || rsp.ready;
    assign req.ready = en;

    // ------------------------------------------------------------------
    // stage 0: input register
    // ------------------------------------------------------------------
    logic                      v0_reg;
    logic signed [COORD_W-1:0] ox0_reg, oy0_reg, dx0_reg, dy0_reg, bx0_reg, by0_reg;
    logic        [SIZE_W-1:0]  bw0_reg, bh0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (en)
            v0_reg <= req.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ox0_reg <= req.origin_x;
            oy0_reg <= req.origin_y;
            dx0_reg <= req.dir_x;
            dy0_reg <= req.dir_y;
            bx0_reg <= req.box_x;
            by0_reg <= req.box_y;
            bw0_reg <= req.box_w;
            bh0_reg <= req.box_h;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: slab distances, magnitudes and signs
    // ------------------------------------------------------------------
    logic signed [COORD_W+1:0] ax, bx, ay, by;
    logic        [COORD_W:0]   max_a, max_b, may_a, may_b;
    logic        [DEN_W-1:0]   dmx, dmy;
    side_t                     side_next;

    always_comb
    begin
        ax = (COORD_W+2)'(bx0_reg) - (COORD_W+2)'(ox0_reg);
        bx = ax + $signed({3'b000, bw0_reg});
        ay = (COORD_W+2)'(by0_reg) - (COORD_W+2)'(oy0_reg);
        by = ay + $signed({3'b000, bh0_reg});

        max_a = ax[COORD_W+1] ? (COORD_W+1)'(-ax) : ax[COORD_W:0];
        max_b = bx[COORD_W+1] ? (COORD_W+1)'(-bx) : bx[COORD_W:0];
        may_a = ay[COORD_W+1] ? (COORD_W+1)'(-ay) : ay[COORD_W:0];
        may_b = by[COORD_W+1] ? (COORD_W+1)'(-by) : by[COORD_W:0];

        dmx = dx0_reg[COORD_W-1] ? (~dx0_reg + 1'b1) : dx0_reg;
        dmy = dy0_reg[COORD_W-1] ? (~dy0_reg + 1'b1) : dy0_reg;

        side_next.origin_x = ox0_reg;
        side_next.origin_y = oy0_reg;
        side_next.dir_x    = dx0_reg;
        side_next.dir_y    = dy0_reg;
        side_next.neg_xa   = ax[COORD_W+1] ^ dx0_reg[COORD_W-1];
        side_next.neg_xb   = bx[COORD_W+1] ^ dx0_reg[COORD_W-1];
        side_next.neg_ya   = ay[COORD_W+1] ^ dy0_reg[COORD_W-1];
        side_next.neg_yb   = by[COORD_W+1] ^ dy0_reg[COORD_W-1];
        side_next.zero_x   = (dx0_reg == '0);
        side_next.zero_y   = (dy0_reg == '0);
        // origin inside the closed slab: edge - org <= 0 and far edge - org >= 0
        side_next.slab_x   = (ax[COORD_W+1] || (ax == '0)) && !bx[COORD_W+1];
        side_next.slab_y   = (ay[COORD_W+1] || (ay == '0)) && !by[COORD_W+1];
    end

    logic                v1_reg;
    logic [NUM_W-1:0]    nxa_reg, nxb_reg, nya_reg, nyb_reg;
    logic [DEN_W-1:0]    dmx_reg, dmy_reg;
    side_t               side1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= v0_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nxa_reg   <= {max_a, {FRAC_BITS{1'b0}}};
            nxb_reg   <= {max_b, {FRAC_BITS{1'b0}}};
            nya_reg   <= {may_a, {FRAC_BITS{1'b0}}};
            nyb_reg   <= {may_b, {FRAC_BITS{1'b0}}};
            dmx_reg   <= dmx;
            dmy_reg   <= dmy;
            side1_reg <= side_next;
        end
    end

    // ------------------------------------------------------------------
    // divider stages, with valid bits and side data beside them
    // ------------------------------------------------------------------
    logic [NUM_W-1:0] qxa, qxb, qya, qyb;

    rbsi_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div_xa (
        .clk(clk), .en(en), .num(nxa_reg), .den(dmx_reg), .quo(qxa)
    );
    rbsi_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div_xb (
        .clk(clk), .en(en), .num(nxb_reg), .den(dmx_reg), .quo(qxb)
    );
    rbsi_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div_ya (
        .clk(clk), .en(en), .num(nya_reg), .den(dmy_reg), .quo(qya)
    );
    rbsi_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div_yb (
        .clk(clk), .en(en), .num(nyb_reg), .den(dmy_reg), .quo(qyb)
    );

    logic [NUM_W-1:0] vd_reg;
    side_t            sided_reg [NUM_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vd_reg <= '0;
        else if (en)
            vd_reg <= {vd_reg[NUM_W-2:0], v1_reg};
    end

    for (genvar i = 0; i < NUM_W; i++)
    begin : g_side
        always_ff @(posedge clk)
        begin
            if (en)
                sided_reg[i] <= (i == 0) ? side1_reg : sided_reg[(i == 0) ? 0 : i-1];
        end
    end

    // ------------------------------------------------------------------
    // p1: signed times, ordering, unbounded axes
    // ------------------------------------------------------------------
    side_t                sd;
    logic signed [TW-1:0] txa, txb, tya, tyb;
    logic signed [TW-1:0] nx_next, fx_next, ny_next, fy_next;

    always_comb
    begin
        sd  = sided_reg[NUM_W-1];
        txa = to_time(qxa, sd.neg_xa);
        txb = to_time(qxb, sd.neg_xb);
        tya = to_time(qya, sd.neg_ya);
        tyb = to_time(qyb, sd.neg_yb);
        if (sd.zero_x)
        begin
            nx_next = T_NEG_INF;
            fx_next = T_POS_INF;
        end
        else
        begin
            nx_next = (txa > txb) ? txb : txa;
            fx_next = (txa > txb) ? txa : txb;
        end
        if (sd.zero_y)
        begin
            ny_next = T_NEG_INF;
            fy_next = T_POS_INF;
        end
        else
        begin
            ny_next = (tya > tyb) ? tyb : tya;
            fy_next = (tya > tyb) ? tya : tyb;
        end
    end

    logic                      v_p1_reg;
    logic signed [TW-1:0]      nx_reg, fx_reg, ny_reg, fy_reg;
    logic                      okx_reg, oky_reg;
    logic signed [COORD_W-1:0] ox1_reg, oy1_reg, dx1_reg, dy1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_p1_reg <= 1'b0;
        else if (en)
            v_p1_reg <= vd_reg[NUM_W-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nx_reg  <= nx_next;
            fx_reg  <= fx_next;
            ny_reg  <= ny_next;
            fy_reg  <= fy_next;
            okx_reg <= !sd.zero_x || sd.slab_x;
            oky_reg <= !sd.zero_y || sd.slab_y;
            ox1_reg <= sd.origin_x;
            oy1_reg <= sd.origin_y;
            dx1_reg <= sd.dir_x;
            dy1_reg <= sd.dir_y;
        end
    end

    // ------------------------------------------------------------------
    // p2: interval overlap, hit interval, entry axis
    // ------------------------------------------------------------------
    logic                      v_p2_reg;
    logic                      miss_reg, gx_reg, gy_reg;
    logic signed [TW-1:0]      tnear_reg, tfar_reg;
    logic signed [COORD_W-1:0] ox2_reg, oy2_reg, dx2_reg, dy2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_p2_reg <= 1'b0;
        else if (en)
            v_p2_reg <= v_p1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            miss_reg  <= !okx_reg || !oky_reg || (nx_reg > fy_reg) || (ny_reg > fx_reg);
            tnear_reg <= (nx_reg > ny_reg) ? nx_reg : ny_reg;
            tfar_reg  <= (fx_reg < fy_reg) ? fx_reg : fy_reg;
            gx_reg    <= (nx_reg > ny_reg);
            gy_reg    <= (nx_reg < ny_reg);
            ox2_reg   <= ox1_reg;
            oy2_reg   <= oy1_reg;
            dx2_reg   <= dx1_reg;
            dy2_reg   <= dy1_reg;
        end
    end

    // ------------------------------------------------------------------
    // p3: behind-ray reject, saturated near time, normal
    // ------------------------------------------------------------------
    logic                      v_p3_reg;
    logic                      hit3_reg;
    logic signed [COORD_W-1:0] sn_reg;
    logic signed [NORM_W-1:0]  nrx3_reg, nry3_reg;
    logic signed [COORD_W-1:0] ox3_reg, oy3_reg, dx3_reg, dy3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_p3_reg <= 1'b0;
        else if (en)
            v_p3_reg <= v_p2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit3_reg <= !miss_reg && !tfar_reg[TW-1];
            sn_reg   <= sat_time(tnear_reg);
            nrx3_reg <= gx_reg ? (dx2_reg[COORD_W-1] ? NORM_POS : NORM_NEG) : NORM_ZERO;
            nry3_reg <= gy_reg ? (dy2_reg[COORD_W-1] ? NORM_POS : NORM_NEG) : NORM_ZERO;
            ox3_reg  <= ox2_reg;
            oy3_reg  <= oy2_reg;
            dx3_reg  <= dx2_reg;
            dy3_reg  <= dy2_reg;
        end
    end

    // ------------------------------------------------------------------
    // p4: contact products
    // ------------------------------------------------------------------
    logic                      v_p4_reg;
    logic                      hit4_reg;
    logic signed [COORD_W-1:0] sn4_reg;
    logic signed [NORM_W-1:0]  nrx4_reg, nry4_reg;
    logic signed [COORD_W-1:0] ox4_reg, oy4_reg;
    logic signed [PW-1:0]      px_reg, py_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_p4_reg <= 1'b0;
        else if (en)
            v_p4_reg <= v_p3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit4_reg <= hit3_reg;
            sn4_reg  <= sn_reg;
            nrx4_reg <= nrx3_reg;
            nry4_reg <= nry3_reg;
            ox4_reg  <= ox3_reg;
            oy4_reg  <= oy3_reg;
            px_reg   <= PW'(sn_reg) * PW'(dx3_reg);
            py_reg   <= PW'(sn_reg) * PW'(dy3_reg);
        end
    end

    // ------------------------------------------------------------------
    // p5: floor shift, add origin, saturate, output register
    // ------------------------------------------------------------------
    logic signed [PW-1:0] shx, shy;
    logic signed [PW:0]   sumx, sumy;

    always_comb
    begin
        shx  = px_reg >>> FRAC_BITS;
        shy  = py_reg >>> FRAC_BITS;
        sumx = (PW+1)'(shx) + (PW+1)'(ox4_reg);
        sumy = (PW+1)'(shy) + (PW+1)'(oy4_reg);
    end

    logic                      out_valid_reg;
    logic                      hit_reg;
    logic signed [COORD_W-1:0] near_reg, cx_reg, cy_reg;
    logic signed [NORM_W-1:0]  nrx_reg, nry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= v_p4_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg  <= hit4_reg;
            near_reg <= hit4_reg ? sn4_reg : '0;
            cx_reg   <= hit4_reg ? sat_pos(sumx) : '0;
            cy_reg   <= hit4_reg ? sat_pos(sumy) : '0;
            nrx_reg  <= hit4_reg ? nrx4_reg : NORM_ZERO;
            nry_reg  <= hit4_reg ? nry4_reg : NORM_ZERO;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.hit       = hit_reg;
    assign rsp.near_time = near_reg;
    assign rsp.contact_x = cx_reg;
    assign rsp.contact_y = cy_reg;
    assign rsp.normal_x  = nrx_reg;
    assign rsp.normal_y  = nry_reg;

endmodule

// ===== sv/rbsi_div.sv =====
// ----------------------------------------------------------------------------
// rbsi_div
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module rbsi_div #(
    parameter int NUM_W = 49,
    parameter int DEN_W = 32
) (
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [NUM_W-1:0] quo
);

    // per stage: partial remainder, numerator/quotient shift word, divisor
    logic [DEN_W-1:0] rem_reg [NUM_W];
    logic [NUM_W-1:0] sh_reg  [NUM_W];
    logic [DEN_W-1:0] den_reg [NUM_W];

    for (genvar i = 0; i < NUM_W; i++)
    begin : g_stage
        logic [DEN_W-1:0] rem_in;
        logic [DEN_W-1:0] den_in;
        logic [NUM_W-1:0] sh_in;
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;
        logic             take;

        if (i == 0)
        begin : g_first
            assign rem_in = '0;
            assign sh_in  = num;
            assign den_in = den;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[i-1];
            assign sh_in  = sh_reg[i-1];
            assign den_in = den_reg[i-1];
        end

        // bring down next numerator bit and try the subtract
        assign trial = {rem_in, sh_in[NUM_W-1]};
        assign diff  = trial - {1'b0, den_in};
        assign take  = (trial >= {1'b0, den_in});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                sh_reg[i]  <= {sh_in[NUM_W-2:0], take};
                den_reg[i] <= den_in;
            end
        end
    end

    assign quo = sh_reg[NUM_W-1];

endmodule

// ===== sv/rbsi_checker.sv =====
// ----------------------------------------------------------------------------
// rbsi_checker
// Port-level checks on the ray/box slab intersect block, bound to the top.
// ----------------------------------------------------------------------------
module rbsi_checker
    import rbsi_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic                      hit,
    input logic signed [COORD_W-1:0] near_time,
    input logic signed [COORD_W-1:0] contact_x,
    input logic signed [COORD_W-1:0] contact_y,
    input logic signed [NORM_W-1:0]  normal_x,
    input logic signed [NORM_W-1:0]  normal_y
);

    // a miss carries all-zero fields
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> near_time == '0 && contact_x == '0 && contact_y == '0
                              && normal_x == NORM_ZERO && normal_y == NORM_ZERO)
        else $error("miss item with nonzero fields");

    // at most one normal component is set
    a_one_face: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> normal_x == NORM_ZERO || normal_y == NORM_ZERO)
        else $error("both normal components nonzero");

    // normal components are -1, 0 or 1
    a_norm_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (normal_x == NORM_NEG || normal_x == NORM_ZERO || normal_x == NORM_POS)
                   && (normal_y == NORM_NEG || normal_y == NORM_ZERO || normal_y == NORM_POS))
        else $error("normal component out of range");

    // an empty output stage never blocks the input
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(near_time) && $stable(hit))
        else $error("stalled result changed");

endmodule

bind ray_box_slab_intersect rbsi_checker u_rbsi_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .hit       (rsp.hit),
    .near_time (rsp.near_time),
    .contact_x (rsp.contact_x),
    .contact_y (rsp.contact_y),
    .normal_x  (rsp.normal_x),
    .normal_y  (rsp.normal_y)
);
